// ===== hw/rtl/deadline_timer_table_top_defines.svh =====
// Assertion macros used by the port-level checker of the deadline timer table.
`ifndef DEADLINE_TIMER_TABLE_TOP_DEFINES_SVH
`define DEADLINE_TIMER_TABLE_TOP_DEFINES_SVH

// Asserts that an antecedent implies a consequent in the same cycle.
`define DTT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Asserts that an antecedent implies a consequent in the following cycle.
`define DTT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hw/rtl/dtt_pkg.sv =====
// Package with the types, codes and constants of the deadline timer table.
`default_nettype none
package dtt_pkg;

  localparam int unsigned SlotsDefault = 32;
  localparam int unsigned MaxSlots     = 64;
  localparam logic [31:0] WindowReset  = 32'd3600000;
  localparam logic [63:0] AllOnes      = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef enum logic [2:0] {
    CMD_ADD     = 3'd0,
    CMD_CANCEL  = 3'd1,
    CMD_REFRESH = 3'd2,
    CMD_RESET   = 3'd3,
    CMD_WAIT    = 3'd4,
    CMD_EXPIRE  = 3'd5,
    CMD_RSVD6   = 3'd6,
    CMD_RSVD7   = 3'd7
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_INACTIVE = 2'd1,
    ST_FULL     = 2'd2,
    ST_NONE     = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_TGT_RD,
    S_TGT_WR,
    S_FCHK,
    S_EXP_SCAN,
    S_EXP_WR,
    S_OUT
  } state_e;

  typedef struct packed {
    logic [1:0]  status;
    logic [4:0]  timer_slot;
    logic [63:0] wait_ms;
    logic        front_notice;
    logic        last;
  } result_t;

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [31:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {33'd0, b};
    return s[64] ? AllOnes : s[63:0];
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/dtt_mem.sv =====
// Slot store: period and deadline memory with registered read.
`default_nettype none
module dtt_mem #(
  parameter int unsigned Slots = 32,
  parameter int unsigned IdxW  = 5
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [IdxW-1:0] waddr_i,
  input  logic [31:0]     wper_i,
  input  logic [63:0]     wdl_i,
  input  logic [IdxW-1:0] raddr_i,
  output logic [31:0]     rper_o,
  output logic [63:0]     rdl_o
);
  logic [95:0] mem_q [Slots];
  logic [95:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= {wper_i, wdl_i};
    end
    rd_q <= mem_q[raddr_i];
  end

  assign rper_o = rd_q[95:64];
  assign rdl_o  = rd_q[63:0];
endmodule
`default_nettype wire

// ===== hw/rtl/deadline_timer_table_top.sv =====
// Top level of the deadline timer table: control sequencer around the slot store.
//
//  channel | direction | handshake          | word
//  in      | input     | in_valid/in_stall  | cmd, now_ms, slot, period_ms, flags
//  out     | output    | out_valid/out_stall| status, timer_slot, wait_ms, notice, last
//  cfg     | input     | cfg_valid/cfg_ready| rollover window
//
// Every command first walks the store once.
// Cancel, refresh, next_wait and a reset that keeps its period answer without a second walk.
// Add to a table with a free slot and a real reset walk the store again for the front check.
// Expire makes one pass over the store per emitted word, in deadline order.
// Reset clears the active, recurring and due marks, the check time and the notice flag.
// A stalled output holds its word and the sequencer waits in its output state.
`default_nettype none
module deadline_timer_table_top #(
  parameter int unsigned Slots = dtt_pkg::SlotsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  cmd_i,
  input  logic [63:0] now_ms_i,
  input  logic [4:0]  slot_i,
  input  logic [31:0] period_ms_i,
  input  logic        recurring_i,
  input  logic        from_now_i,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status_o,
  output logic [4:0]  timer_slot_o,
  output logic [63:0] wait_ms_o,
  output logic        front_notice_o,
  output logic        last_o,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data_i
);
  import dtt_pkg::*;

  localparam int unsigned IdxW = (Slots > 1) ? $clog2(Slots) : 1;
  localparam int unsigned CntW = $clog2(Slots + 1);

  state_e state_q, state_d;
  logic [Slots-1:0] act_q, act_d, rec_q, rec_d, due_q, due_d;
  logic [31:0] win_q;
  logic [63:0] lct_q, lct_d;
  logic        fp_q, fp_d;

  cmd_e        cmd_q, cmd_d;
  logic [63:0] now_q, now_d;
  logic [4:0]  slot_q, slot_d;
  logic [31:0] per_q, per_d;
  logic        recin_q, recin_d, fnow_q, fnow_d;

  logic [CntW-1:0] cnt_q, cnt_d;
  logic            rdv_q, rdv_d;
  logic [IdxW-1:0] rdi_q, rdi_d;
  logic            found_q, found_d;
  logic [IdxW-1:0] best_q, best_d;
  logic [63:0]     bdl_q, bdl_d;
  logic [31:0]     bper_q, bper_d;
  logic            front_q, front_d;
  logic [63:0]     tdl_q, tdl_d;
  logic [5:0]      nout_q, nout_d;
  logic            roll_q, roll_d;
  logic [1:0]      ncand_q, ncand_d;

  result_t res_q, res_d;
  result_t out_q, out_d;
  logic    ov_q, ov_d;
  state_e  after_q, after_d;

  logic            we;
  logic [IdxW-1:0] waddr, raddr;
  logic [31:0]     wper, rper;
  logic [63:0]     wdl, rdl;

  logic            tgt_ok;
  logic [IdxW-1:0] tgt;
  logic            rd_act, rd_earlier;
  logic [63:0]     start;
  logic            out_free;
  logic            rst_go;
  logic            exp_last;

  dtt_mem #(.Slots(Slots), .IdxW(IdxW)) u_mem (
    .clk_i(clk_i), .we_i(we), .waddr_i(waddr), .wper_i(wper), .wdl_i(wdl),
    .raddr_i(raddr), .rper_o(rper), .rdl_o(rdl)
  );

  assign tgt_ok   = ({1'b0, slot_q} < 6'(Slots));
  assign tgt      = IdxW'(slot_q);
  assign out_free = !ov_q || !out_stall;
  assign rd_act   = act_q[rdi_q];
  assign rd_earlier = (rdl < bdl_q) || ((rdl == bdl_q) && (rdi_q < best_q));
  assign start    = fnow_q ? now_q : ((rdl >= {32'd0, rper}) ? rdl - {32'd0, rper} : 64'd0);
  assign rst_go   = tgt_ok && !(per_q == rper && !fnow_q) && act_q[tgt];
  assign exp_last = (ncand_q == 2'd1) || (nout_q == 6'd31);

  assign in_stall  = (state_q != S_IDLE);
  assign cfg_ready = (state_q == S_IDLE) && !ov_q;
  assign out_valid = ov_q;
  assign status_o  = out_q.status;
  assign timer_slot_o   = out_q.timer_slot;
  assign wait_ms_o      = out_q.wait_ms;
  assign front_notice_o = out_q.front_notice;
  assign last_o         = out_q.last;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:     if (in_valid) state_d = S_SCAN;
      S_SCAN: begin
        if (cnt_q == CntW'(Slots) && !rdv_q) begin
          priority case (cmd_q)
            CMD_ADD:                            state_d = (&act_q) ? S_OUT : S_TGT_RD;
            CMD_CANCEL, CMD_REFRESH, CMD_RESET: state_d = S_TGT_RD;
            CMD_WAIT:                           state_d = S_OUT;
            CMD_EXPIRE: state_d = (act_q == '0) ? S_OUT : S_EXP_SCAN;
            default:                            state_d = S_IDLE;
          endcase
        end
      end
      S_TGT_RD:   state_d = S_TGT_WR;
      S_TGT_WR: begin
        state_d = (cmd_q == CMD_ADD || (cmd_q == CMD_RESET && rst_go)) ? S_FCHK : S_OUT;
      end
      S_FCHK:     if (cnt_q == CntW'(Slots) && !rdv_q) state_d = S_OUT;
      S_EXP_SCAN: if (cnt_q == CntW'(Slots) && !rdv_q) state_d = S_EXP_WR;
      S_EXP_WR:   state_d = (!found_q && nout_q != 6'd0) ? S_IDLE : S_OUT;
      S_OUT:      if (out_free) state_d = after_q;
      default:    state_d = S_IDLE;
    endcase
  end

  always_comb begin
    act_d = act_q; rec_d = rec_q; due_d = due_q; lct_d = lct_q; fp_d = fp_q;
    cmd_d = cmd_q; now_d = now_q; slot_d = slot_q; per_d = per_q;
    recin_d = recin_q; fnow_d = fnow_q;
    cnt_d = cnt_q; rdv_d = 1'b0; rdi_d = rdi_q;
    found_d = found_q; best_d = best_q; bdl_d = bdl_q; bper_d = bper_q;
    front_d = front_q; tdl_d = tdl_q; nout_d = nout_q; roll_d = roll_q;
    ncand_d = ncand_q;
    res_d = res_q; out_d = out_q; ov_d = ov_q && out_stall; after_d = after_q;
    we = 1'b0; waddr = tgt; wper = per_q; wdl = tdl_q; raddr = IdxW'(cnt_q);
    unique case (state_q)
      S_IDLE: begin
        if (in_valid) begin
          cmd_d = cmd_e'(cmd_i); now_d = now_ms_i; slot_d = slot_i;
          per_d = period_ms_i; recin_d = recurring_i; fnow_d = from_now_i;
          cnt_d = '0; found_d = 1'b0; nout_d = '0; front_d = 1'b1;
          ncand_d = '0;
          after_d = S_IDLE;
          res_d = '{status: ST_OK, timer_slot: 5'd0, wait_ms: 64'd0,
                    front_notice: 1'b0, last: 1'b1};
        end
      end
      S_SCAN: begin
        // Shared walk over the slot store; what it does depends on the command.
        if (cnt_q != CntW'(Slots)) begin
          rdv_d = 1'b1; rdi_d = IdxW'(cnt_q); cnt_d = cnt_q + 1'b1;
        end
        if (rdv_q && rd_act && (!found_q || rd_earlier)) begin
          found_d = 1'b1; best_d = rdi_q; bdl_d = rdl;
        end
        if (cnt_q == CntW'(Slots) && !rdv_q) begin
          cnt_d = '0;
          found_d = 1'b0;
          ncand_d = '0;
          priority case (cmd_q)
            CMD_ADD: begin
              if (&act_q) begin
                res_d.status = ST_FULL;
              end else begin
                slot_d = '0;
                for (int i = Slots - 1; i >= 0; i--) begin
                  if (!act_q[i]) slot_d = 5'(i);
                end
              end
            end
            CMD_CANCEL, CMD_REFRESH, CMD_RESET: ;
            CMD_WAIT: begin
              fp_d = 1'b0;
              res_d.wait_ms = !found_q ? AllOnes :
                              ((now_q >= bdl_q) ? 64'd0 : bdl_q - now_q);
            end
            CMD_EXPIRE: begin
              if (act_q == '0) begin
                res_d.status = ST_NONE;
              end else begin
                roll_d = (lct_q >= {32'd0, win_q}) && (now_q < lct_q - {32'd0, win_q});
                lct_d = now_q;
              end
            end
            default: ;
          endcase
        end
      end
      S_TGT_RD: begin
        raddr = tgt;
        res_d.timer_slot = slot_q;
      end
      S_TGT_WR: begin
        priority case (cmd_q)
          CMD_ADD: begin
            act_d[tgt] = 1'b1; rec_d[tgt] = recin_q;
            we = 1'b1; wdl = sat_add(now_q, per_q); tdl_d = wdl;
          end
          CMD_CANCEL: begin
            if (tgt_ok && act_q[tgt]) act_d[tgt] = 1'b0;
            else res_d.status = ST_INACTIVE;
          end
          CMD_REFRESH: begin
            if (tgt_ok && act_q[tgt]) begin
              we = 1'b1; wper = rper; wdl = sat_add(now_q, rper);
            end else res_d.status = ST_INACTIVE;
          end
          default: begin
            if (!tgt_ok) res_d.status = ST_INACTIVE;
            else if (per_q == rper && !fnow_q) res_d.status = ST_OK;
            else if (!act_q[tgt]) res_d.status = ST_INACTIVE;
            else begin
              we = 1'b1; wdl = sat_add(start, per_q); tdl_d = wdl;
            end
          end
        endcase
      end
      S_FCHK: begin
        if (cnt_q != CntW'(Slots)) begin
          rdv_d = 1'b1; rdi_d = IdxW'(cnt_q); cnt_d = cnt_q + 1'b1;
        end
        if (rdv_q && rdi_q != tgt && rd_act &&
            ((rdl < tdl_q) || ((rdl == tdl_q) && (rdi_q < tgt)))) begin
          front_d = 1'b0;
        end
        if (cnt_q == CntW'(Slots) && !rdv_q) begin
          if (front_q && !fp_q) begin
            fp_d = 1'b1; res_d.front_notice = 1'b1;
          end
        end
      end
      S_EXP_SCAN: begin
        if (cnt_q != CntW'(Slots)) begin
          rdv_d = 1'b1; rdi_d = IdxW'(cnt_q); cnt_d = cnt_q + 1'b1;
        end
        if (rdv_q && rd_act && !due_q[rdi_q] && (roll_q || rdl <= now_q)) begin
          ncand_d = (ncand_q == 2'd2) ? 2'd2 : ncand_q + 2'd1;
          if (!found_q || rd_earlier) begin
            found_d = 1'b1; best_d = rdi_q; bdl_d = rdl; bper_d = rper;
          end
        end
      end
      S_EXP_WR: begin
        cnt_d = '0; found_d = 1'b0; ncand_d = '0;
        if (!found_q) begin
          if (nout_q == 6'd0) begin
            res_d.status = ST_NONE; res_d.timer_slot = 5'd0; res_d.last = 1'b1;
            after_d = S_IDLE;
          end
          due_d = '0;
        end else begin
          due_d[best_q] = 1'b1;
          nout_d = nout_q + 1'b1;
          if (rec_q[best_q]) begin
            we = 1'b1; waddr = best_q; wper = bper_q; wdl = sat_add(now_q, bper_q);
          end else act_d[best_q] = 1'b0;
          res_d.status = ST_OK; res_d.timer_slot = 5'(best_q); res_d.last = exp_last;
          after_d = exp_last ? S_IDLE : S_EXP_SCAN;
          if (exp_last) due_d = '0;
        end
      end
      S_OUT: begin
        if (out_free) begin
          ov_d = 1'b1;
          out_d = res_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; act_q <= '0; rec_q <= '0; due_q <= '0; lct_q <= '0;
      fp_q <= 1'b0; win_q <= WindowReset; ov_q <= 1'b0; cnt_q <= '0;
      rdv_q <= 1'b0; found_q <= 1'b0; nout_q <= '0; after_q <= S_IDLE;
      cmd_q <= CMD_ADD; ncand_q <= '0;
    end else begin
      state_q <= state_d; act_q <= act_d; rec_q <= rec_d; due_q <= due_d;
      lct_q <= lct_d; fp_q <= fp_d; ov_q <= ov_d; cnt_q <= cnt_d;
      rdv_q <= rdv_d; found_q <= found_d; nout_q <= nout_d; after_q <= after_d;
      cmd_q <= cmd_d; ncand_q <= ncand_d;
      if (cfg_valid && cfg_ready) win_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    now_q <= now_d; slot_q <= slot_d; per_q <= per_d; recin_q <= recin_d;
    fnow_q <= fnow_d; rdi_q <= rdi_d; best_q <= best_d; bdl_q <= bdl_d;
    bper_q <= bper_d; front_q <= front_d; tdl_q <= tdl_d; roll_q <= roll_d;
    res_q <= res_d; out_q <= out_d;
  end
endmodule
`default_nettype wire

// ===== hw/rtl/dtt_checker.sv =====
// Port-level checker for the deadline timer table, bound to the top level.
`default_nettype none
`include "deadline_timer_table_top_defines.svh"
module dtt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  status_o,
  input logic        last_o,
  input logic        cfg_ready
);
  import dtt_pkg::*;

  `DTT_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid && out_stall, out_valid)
  `DTT_ASSERT_IMP(a_cfg_idle, clk_i, rst_ni, cfg_ready, !in_stall)
  `DTT_ASSERT_IMP(a_none_last, clk_i, rst_ni, out_valid && status_o == ST_NONE, last_o)
  `DTT_ASSERT_NEXT(a_busy_after, clk_i, rst_ni, in_valid && !in_stall, in_stall)
endmodule

bind deadline_timer_table_top dtt_checker u_dtt_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .status_o(status_o),
  .last_o(last_o), .cfg_ready(cfg_ready)
);
`default_nettype wire

// ===== tb/sv/deadline_timer_table_checker.sv =====
// Checker for the deadline timer table: predicts every result word and compares it.
`timescale 1ns / 1ps
module deadline_timer_table_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [2:0]  cmd_i,
  input  logic [63:0] now_ms_i,
  input  logic [4:0]  slot_i,
  input  logic [31:0] period_ms_i,
  input  logic        recurring_i,
  input  logic        from_now_i,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  status_o,
  input  logic [4:0]  timer_slot_o,
  input  logic [63:0] wait_ms_o,
  input  logic        front_notice_o,
  input  logic        last_o,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [31:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o,
  output logic [31:0] period_known_o
);
  import dtt_pkg::*;

  localparam int NSlots = 32;

  logic [31:0] window_q;
  logic        armed_q [NSlots];
  logic        rearm_q [NSlots];
  logic [31:0] per_q [NSlots];
  logic [63:0] due_at_q [NSlots];
  logic [63:0] last_check_q;
  logic        notice_pending_q;
  result_t     expected_q [$];

  assign pending_o = expected_q.size();

  function automatic logic [63:0] add_sat(input logic [63:0] a, input logic [31:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {33'd0, b};
    return s[64] ? AllOnes : s[63:0];
  endfunction

  function automatic bit sooner(input int a, input int b);
    if (due_at_q[a] != due_at_q[b]) return due_at_q[a] < due_at_q[b];
    return a < b;
  endfunction

  function automatic logic raise_notice(input int s);
    for (int j = 0; j < NSlots; j++)
      if (j != s && armed_q[j] && sooner(j, s)) return 1'b0;
    if (notice_pending_q) return 1'b0;
    notice_pending_q = 1'b1;
    return 1'b1;
  endfunction

  function automatic void push_word(input status_e st, input int ts, input logic [63:0] w,
                                    input logic fn, input logic lst);
    result_t r;
    r.status = st;
    r.timer_slot = ts[4:0];
    r.wait_ms = w;
    r.front_notice = fn;
    r.last = lst;
    expected_q.insert(expected_q.size(), r);
  endfunction

  task automatic predict_command(input logic [2:0] c, input logic [63:0] now, input int s,
                                 input logic [31:0] per, input logic rec, input logic fnow);
    bit found, roll;
    int best, n;
    logic [63:0] start, w;
    logic [NSlots-1:0] due, done;
    int order [NSlots];
    found = 0;
    best = 0;
    n = 0;
    due = '0;
    done = '0;
    case (cmd_e'(c))
      CMD_ADD: begin
        for (int i = 0; i < NSlots && !found; i++) begin
          if (!armed_q[i]) begin
            found = 1;
            armed_q[i] = 1'b1;
            rearm_q[i] = rec;
            per_q[i] = per;
            period_known_o[i] = 1'b1;
            due_at_q[i] = add_sat(now, per);
            push_word(ST_OK, i, '0, raise_notice(i), 1'b1);
          end
        end
        if (!found) push_word(ST_FULL, 0, '0, 1'b0, 1'b1);
      end
      CMD_CANCEL: begin
        if (armed_q[s]) begin
          armed_q[s] = 1'b0;
          push_word(ST_OK, s, '0, 1'b0, 1'b1);
        end else push_word(ST_INACTIVE, s, '0, 1'b0, 1'b1);
      end
      CMD_REFRESH: begin
        if (armed_q[s]) begin
          due_at_q[s] = add_sat(now, per_q[s]);
          push_word(ST_OK, s, '0, 1'b0, 1'b1);
        end else push_word(ST_INACTIVE, s, '0, 1'b0, 1'b1);
      end
      CMD_RESET: begin
        if (per == per_q[s] && !fnow) push_word(ST_OK, s, '0, 1'b0, 1'b1);
        else if (!armed_q[s]) push_word(ST_INACTIVE, s, '0, 1'b0, 1'b1);
        else begin
          if (fnow) start = now;
          else start = (due_at_q[s] >= {32'd0, per_q[s]}) ? due_at_q[s] - per_q[s] : '0;
          per_q[s] = per;
          due_at_q[s] = add_sat(start, per);
          push_word(ST_OK, s, '0, raise_notice(s), 1'b1);
        end
      end
      CMD_WAIT: begin
        notice_pending_q = 1'b0;
        for (int i = 0; i < NSlots; i++)
          if (armed_q[i] && (!found || sooner(i, best))) begin
            best = i;
            found = 1;
          end
        if (!found) w = AllOnes;
        else w = (now >= due_at_q[best]) ? '0 : due_at_q[best] - now;
        push_word(ST_OK, 0, w, 1'b0, 1'b1);
      end
      CMD_EXPIRE: begin
        for (int i = 0; i < NSlots; i++) if (armed_q[i]) found = 1;
        if (!found) push_word(ST_NONE, 0, '0, 1'b0, 1'b1);
        else begin
          roll = last_check_q >= {32'd0, window_q} && now < last_check_q - window_q;
          last_check_q = now;
          for (int i = 0; i < NSlots; i++)
            if (armed_q[i] && (roll || due_at_q[i] <= now)) due[i] = 1'b1;
          if (due == '0) push_word(ST_NONE, 0, '0, 1'b0, 1'b1);
          else begin
            found = 1;
            while (found && n < NSlots) begin
              found = 0;
              for (int i = 0; i < NSlots; i++)
                if (due[i] && !done[i] && (!found || sooner(i, best))) begin
                  best = i;
                  found = 1;
                end
              if (found) begin
                done[best] = 1'b1;
                order[n] = best;
                n++;
              end
            end
            for (int k = 0; k < n; k++) begin
              if (rearm_q[order[k]]) due_at_q[order[k]] = add_sat(now, per_q[order[k]]);
              else armed_q[order[k]] = 1'b0;
              push_word(ST_OK, order[k], '0, 1'b0, k == n - 1);
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t exp_w;
    if (!rst_ni) begin
      window_q <= WindowReset;
      for (int i = 0; i < NSlots; i++) begin
        armed_q[i] = 1'b0;
        rearm_q[i] = 1'b0;
        per_q[i] = '0;
        due_at_q[i] = '0;
      end
      last_check_q = '0;
      notice_pending_q = 1'b0;
      period_known_o = '0;
      fail_count_o = 0;
      expected_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) window_q <= cfg_data_i;
      if (in_valid && !in_stall)
        predict_command(cmd_i, now_ms_i, slot_i, period_ms_i, recurring_i, from_now_i);
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result word, slot %0d", timer_slot_o);
          fail_count_o++;
        end else begin
          exp_w = expected_q.pop_front();
          if (status_o !== exp_w.status) begin
            $error("status expected %0d actual %0d", exp_w.status, status_o);
            fail_count_o++;
          end
          if (timer_slot_o !== exp_w.timer_slot) begin
            $error("timer_slot expected %0d actual %0d", exp_w.timer_slot, timer_slot_o);
            fail_count_o++;
          end
          if (wait_ms_o !== exp_w.wait_ms) begin
            $error("wait_ms expected %0h actual %0h", exp_w.wait_ms, wait_ms_o);
            fail_count_o++;
          end
          if (front_notice_o !== exp_w.front_notice) begin
            $error("front_notice expected %0b actual %0b", exp_w.front_notice,
                   front_notice_o);
            fail_count_o++;
          end
          if (last_o !== exp_w.last) begin
            $error("last expected %0b actual %0b", exp_w.last, last_o);
            fail_count_o++;
          end
        end
      end
    end
  end
endmodule

// ===== tb/sv/tb_deadline_timer_table_top.sv =====
// Testbench top for the deadline timer table: stimulus, idling, drain and verdict.
`timescale 1ns / 1ps
module tb_deadline_timer_table_top;
  import dtt_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  cmd_i = CMD_WAIT;
  logic [63:0] now_ms_i = '0;
  logic [4:0]  slot_i = '0;
  logic [31:0] period_ms_i = '0;
  logic        recurring_i = 1'b0;
  logic        from_now_i = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  status_o;
  logic [4:0]  timer_slot_o;
  logic [63:0] wait_ms_o;
  logic        front_notice_o;
  logic        last_o;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data_i = '0;
  int          fail_count;
  int          pending;
  logic [31:0] period_known;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  logic [63:0] clock_ms = '0;

  always #10 clk_i = ~clk_i;

  deadline_timer_table_top dut (.*);

  deadline_timer_table_checker u_checker (
    .*,
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .period_known_o(period_known)
  );

  always @(negedge clk_i) out_stall <= ($urandom_range(99) < recv_stall_pct);

  task automatic send_word(input cmd_e c, input logic [63:0] now, input int s,
                           input logic [31:0] per, input logic rec, input logic fnow);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    cmd_i <= c;
    now_ms_i <= now;
    slot_i <= s[4:0];
    period_ms_i <= per;
    recurring_i <= rec;
    from_now_i <= fnow;
    do @(posedge clk_i); while (in_stall);
    @(negedge clk_i);
  endtask

  task automatic drain_and_write(input logic [31:0] window);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data_i <= window;
    do @(posedge clk_i); while (!cfg_ready);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_word();
    int pick, s;
    logic [31:0] per;
    logic fnow;
    pick = $urandom_range(99);
    s = $urandom_range(31);
    per = ($urandom_range(9) == 0) ? $urandom : $urandom_range(120);
    fnow = 1'($urandom_range(1));
    if ($urandom_range(19) == 0) clock_ms = {$urandom, $urandom};
    else if ($urandom_range(14) == 0 && clock_ms > 64'd5000000) clock_ms -= 64'd4000000;
    else if ($urandom_range(14) == 0 && clock_ms > 64'd500)
      clock_ms -= 64'($urandom_range(500));
    else clock_ms += 64'($urandom_range(40));
    if (!fnow && !period_known[s]) fnow = 1'b1;
    if (pick < 30) send_word(CMD_ADD, clock_ms, s, per, 1'($urandom_range(1)), fnow);
    else if (pick < 40) send_word(CMD_CANCEL, clock_ms, s, per, 1'b0, fnow);
    else if (pick < 50) send_word(CMD_REFRESH, clock_ms, s, per, 1'b1, fnow);
    else if (pick < 65) send_word(CMD_RESET, clock_ms, s, per, 1'b0, fnow);
    else if (pick < 77) send_word(CMD_WAIT, clock_ms, s, per, 1'b0, fnow);
    else if (pick < 97) send_word(CMD_EXPIRE, clock_ms, s, per, 1'b0, fnow);
    else send_word(($urandom_range(1) != 0) ? CMD_RSVD6 : CMD_RSVD7, clock_ms, s, per,
                   1'b1, 1'b1);
  endtask

  initial begin
    #50_000_000;
    $display("FAIL deadline_timer_table_top");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    drain_and_write(WindowReset);
    send_word(CMD_WAIT, 64'd0, 0, 32'd0, 1'b0, 1'b0);
    send_word(CMD_EXPIRE, 64'd0, 0, 32'd0, 1'b0, 1'b0);
    send_word(CMD_CANCEL, 64'd5, 3, 32'd0, 1'b0, 1'b0);
    send_word(CMD_REFRESH, 64'd5, 31, 32'd0, 1'b0, 1'b0);
    send_word(CMD_RESET, 64'd5, 0, 32'd7, 1'b0, 1'b1);
    send_word(CMD_ADD, 64'd100, 0, 32'd50, 1'b1, 1'b0);
    send_word(CMD_ADD, 64'd100, 0, 32'd10, 1'b0, 1'b0);
    send_word(CMD_WAIT, 64'd105, 0, 32'd0, 1'b0, 1'b0);
    send_word(CMD_ADD, AllOnes, 0, 32'hFFFF_FFFF, 1'b1, 1'b0);
    send_word(CMD_RESET, 64'd106, 1, 32'd10, 1'b0, 1'b0);
    send_word(CMD_RESET, 64'd106, 1, 32'd3, 1'b0, 1'b0);
    send_word(CMD_RESET, 64'd120, 0, 32'd0, 1'b1, 1'b1);
    send_word(CMD_REFRESH, 64'd200, 2, 32'd0, 1'b0, 1'b0);
    send_word(CMD_WAIT, AllOnes, 0, 32'd0, 1'b0, 1'b0);
    send_word(CMD_EXPIRE, 64'd200, 0, 32'd0, 1'b0, 1'b0);
    send_word(CMD_EXPIRE, 64'd0, 0, 32'd0, 1'b0, 1'b0);
    send_word(CMD_RSVD6, 64'd1, 7, 32'd1, 1'b1, 1'b1);
    send_word(CMD_RSVD7, 64'd1, 7, 32'd1, 1'b1, 1'b1);
    for (int i = 0; i < 33; i++)
      send_word(CMD_ADD, 64'd300, 0, $urandom_range(3), 1'($urandom_range(1)), 1'b0);
    send_word(CMD_EXPIRE, AllOnes, 0, 32'd0, 1'b0, 1'b0);
    send_word(CMD_EXPIRE, 64'd0, 0, 32'd0, 1'b0, 1'b0);
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          drain_and_write(32'd0);
          send_idle_pct = 16;
          recv_stall_pct = 63;
        end
        1: begin
          drain_and_write(32'hFFFF_FFFF);
          send_idle_pct = 63;
          recv_stall_pct = 16;
        end
        default: begin
          drain_and_write(32'd1000);
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
      endcase
      clock_ms = 64'd6000000;
      for (int n = 0; n < 50; n++) random_word();
    end
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (300) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS deadline_timer_table_top");
    end else begin
      $display("FAIL deadline_timer_table_top");
    end
    $finish;
  end
endmodule

// ===== deadline_timer_table_top.f =====
+incdir+hw/rtl
hw/rtl/dtt_pkg.sv
hw/rtl/dtt_mem.sv
hw/rtl/deadline_timer_table_top.sv
hw/rtl/dtt_checker.sv
tb/sv/deadline_timer_table_checker.sv
tb/sv/tb_deadline_timer_table_top.sv
